[design/cspu_pkg.sv]
// ----------------------------------------------------------------------------
// cspu_pkg
// Shared types, constants and bit helpers for the CAN signal pack/unpack block.
// ----------------------------------------------------------------------------
`default_nettype none

package cspu_pkg;

  localparam int FrameBitsDef = 64;
  localparam int DivSteps     = 64;
  localparam logic [31:0] UnitScale = 32'h0001_0000;

  typedef enum logic [2:0] {
    CFG_START_BIT = 3'd0,
    CFG_LENGTH    = 3'd1,
    CFG_MOTOROLA  = 3'd2,
    CFG_SIGNED    = 3'd3,
    CFG_SCALE     = 3'd4,
    CFG_OFFSET    = 3'd5
  } cfg_idx_t;

  // Static signal description, driven from the configuration registers
  typedef struct packed {
    logic [5:0]  sig_start;
    logic [6:0]  sig_len;
    logic        motorola;
    logic        signed_sig;
    logic [31:0] smag;
    logic        sneg;
    logic [63:0] offset;
  } cspu_cfg_t;

  // Item state handed from one divider cell to the next
  typedef struct packed {
    logic        valid;
    logic        mode;
    logic        dneg;
    logic [63:0] frame;
    logic [63:0] phys;
    logic [31:0] rem;
    logic [63:0] dq;
  } cspu_cell_t;

  // Reverse the bit order inside every byte (Motorola bit sequence <-> frame)
  function automatic logic [63:0] byte_rev(input logic [63:0] v);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) begin
      for (int i = 0; i < 8; i++) begin
        r[b*8 + i] = v[b*8 + 7 - i];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] bit_rev(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = v[63 - i];
    end
    return r;
  endfunction

  function automatic logic [63:0] len_mask(input logic [6:0] len);
    return ~({64{1'b1}} << len);
  endfunction

endpackage

`default_nettype wire

[design/cspu_front.sv]
// ----------------------------------------------------------------------------
// cspu_front
// Field extraction, decode multiply/offset/saturate and encode difference.
// ----------------------------------------------------------------------------
`default_nettype none

module cspu_front
  import cspu_pkg::*;
#(
  parameter int FRAME_BITS = FrameBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire cspu_cfg_t   cfg,
  input  wire logic        in_take,
  input  wire logic        mode,
  input  wire logic [63:0] frame_data,
  input  wire logic [63:0] physical_in,
  output cspu_cell_t       c_out
);

  localparam int VisBits = (FRAME_BITS < 64) ? FRAME_BITS : 64;
  localparam logic [63:0] VisMask = ~({64{1'b1}} << VisBits);

  // stage 1
  logic        v1, mode1, dneg1;
  logic [63:0] frame1, raw1, dmag1;
  // stage 2
  logic        v2, mode2, dneg2, vneg2;
  logic [63:0] frame2, dmag2, vmag2;
  // stage 3
  logic        v3, mode3, dneg3, pneg3;
  logic [63:0] frame3, dmag3, p0_3, p1_3;
  // stage 4
  logic        v4, mode4, dneg4;
  logic [63:0] frame4, dmag4;
  logic [127:0] prod4;
  // stage 5
  logic        v5, mode5, dneg5;
  logic [63:0] frame5, dmag5, phys5;

  logic [63:0] fm, raw_intel, seq_frame, seq_shift, raw_moto, raw_c;
  logic [5:0]  seq0;
  logic [5:0]  sign_idx;
  logic        pneg, oneg, dneg_c;
  logic [63:0] pmag, omag, dmag_c, sx;
  logic [127:0] full, sum;

  always_comb begin
    fm        = frame_data & VisMask;
    raw_intel = (fm >> cfg.sig_start) & len_mask(cfg.sig_len);
    seq0      = {cfg.sig_start[5:3], ~cfg.sig_start[2:0]};
    seq_frame = byte_rev(fm);
    seq_shift = seq_frame >> seq0;
    raw_moto  = bit_rev(seq_shift) >> (7'd64 - cfg.sig_len);
    raw_c     = cfg.motorola ? raw_moto : raw_intel;

    // physical_in - offset as sign and magnitude
    pneg = physical_in[63];
    oneg = cfg.offset[63];
    pmag = pneg ? (64'd0 - physical_in) : physical_in;
    omag = oneg ? (64'd0 - cfg.offset) : cfg.offset;
    if (pneg != oneg) begin
      dneg_c = pneg;
      dmag_c = pmag + omag;
    end else if (pmag >= omag) begin
      dneg_c = pneg;
      dmag_c = pmag - omag;
    end else begin
      dneg_c = !pneg;
      dmag_c = omag - pmag;
    end

    sign_idx = 6'(cfg.sig_len - 7'd1);
    sx   = raw1 | ({64{1'b1}} << cfg.sig_len);
    full = {64'd0, p0_3} + {32'd0, p1_3, 32'd0};
    sum  = prod4 + {{64{cfg.offset[63]}}, cfg.offset};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1  <= mode;
      frame1 <= frame_data;
      raw1   <= raw_c;
      dneg1  <= dneg_c;
      dmag1  <= dmag_c;

      mode2  <= mode1;
      frame2 <= frame1;
      dneg2  <= dneg1;
      dmag2  <= dmag1;
      vneg2  <= cfg.signed_sig && raw1[sign_idx];
      vmag2  <= (cfg.signed_sig && raw1[sign_idx]) ? (64'd0 - sx) : raw1;

      mode3  <= mode2;
      frame3 <= frame2;
      dneg3  <= dneg2;
      dmag3  <= dmag2;
      pneg3  <= vneg2 != cfg.sneg;
      p0_3   <= vmag2[31:0] * cfg.smag;
      p1_3   <= vmag2[63:32] * cfg.smag;

      mode4  <= mode3;
      frame4 <= frame3;
      dneg4  <= dneg3;
      dmag4  <= dmag3;
      prod4  <= pneg3 ? (128'd0 - full) : full;

      mode5  <= mode4;
      frame5 <= frame4;
      dneg5  <= dneg4;
      dmag5  <= dmag4;
      if (sum[127:64] == {64{sum[63]}}) begin
        phys5 <= sum[63:0];
      end else begin
        phys5 <= sum[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
    end
  end

  always_comb begin
    c_out.valid = v5;
    c_out.mode  = mode5;
    c_out.dneg  = dneg5;
    c_out.frame = frame5;
    c_out.phys  = phys5;
    c_out.rem   = 32'd0;
    c_out.dq    = dmag5;
  end

endmodule

`default_nettype wire

[design/cspu_cell.sv]
// ----------------------------------------------------------------------------
// cspu_cell
// One restoring division step: one quotient bit per cell, item passed on.
// ----------------------------------------------------------------------------
`default_nettype none

module cspu_cell
  import cspu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [31:0] smag,
  input  wire cspu_cell_t  c_in,
  output cspu_cell_t       c_out
);

  logic [32:0] rem2;
  logic        ge;
  logic [32:0] diff;

  always_comb begin
    rem2 = {c_in.rem, c_in.dq[63]};
    ge   = rem2 >= {1'b0, smag};
    diff = rem2 - {1'b0, smag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_out.valid <= 1'b0;
    end else if (en) begin
      c_out.valid <= c_in.valid;
      c_out.mode  <= c_in.mode;
      c_out.dneg  <= c_in.dneg;
      c_out.frame <= c_in.frame;
      c_out.phys  <= c_in.phys;
      c_out.rem   <= ge ? diff[31:0] : rem2[31:0];
      c_out.dq    <= {c_in.dq[62:0], ge};
    end
  end

endmodule

`default_nettype wire

[design/cspu_back.sv]
// ----------------------------------------------------------------------------
// cspu_back
// Rounding, range clamp, field insertion and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cspu_back
  import cspu_pkg::*;
#(
  parameter int FRAME_BITS = FrameBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire cspu_cfg_t   cfg,
  input  wire cspu_cell_t  c_in,
  output logic             out_valid,
  output logic [63:0]      physical_out,
  output logic [63:0]      frame_out,
  output logic             ok
);

  localparam int VisBits = (FRAME_BITS < 64) ? FRAME_BITS : 64;
  localparam logic [63:0] VisMask = ~({64{1'b1}} << VisBits);

  logic        v1, mode1;
  logic [63:0] frame1, phys1, val1;

  logic [63:0] q, maxn, maxp, val, lmask;
  logic        neg, len_ok;
  logic [63:0] new_intel, seq_frame, tv, seq_new, new_moto, new_frame;
  logic [5:0]  seq0;

  always_comb begin
    lmask = len_mask(cfg.sig_len);
    q = c_in.dq;
    if ({c_in.rem, 1'b0} >= {1'b0, cfg.smag}) begin
      q = c_in.dq + 64'd1;
    end
    neg = (c_in.dneg != cfg.sneg) && (q != 64'd0);
    if (cfg.signed_sig) begin
      maxn = 64'd1 << (cfg.sig_len - 7'd1);
      maxp = maxn - 64'd1;
    end else begin
      maxn = 64'd0;
      maxp = (cfg.sig_len >= 7'd64) ? 64'h7FFF_FFFF_FFFF_FFFF : lmask;
    end
    if (neg) begin
      val = 64'd0 - ((q > maxn) ? maxn : q);
    end else begin
      val = (q > maxp) ? maxp : q;
    end
    val = val & lmask;

    // insert into the frame
    new_intel = (frame1 & ~(lmask << cfg.sig_start)) | ((val1 & lmask) << cfg.sig_start);
    seq0      = {cfg.sig_start[5:3], ~cfg.sig_start[2:0]};
    seq_frame = byte_rev(frame1);
    tv        = bit_rev(val1 << (7'd64 - cfg.sig_len));
    seq_new   = (seq_frame & ~(lmask << seq0)) | ((tv & lmask) << seq0);
    new_moto  = byte_rev(seq_new);
    new_frame = cfg.motorola ? new_moto : new_intel;
    len_ok    = (cfg.sig_len != 7'd0) && (cfg.sig_len <= 7'd64);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= c_in.valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1  <= c_in.mode;
      frame1 <= c_in.frame;
      phys1  <= c_in.phys;
      val1   <= val;

      ok <= len_ok;
      if (!len_ok) begin
        physical_out <= 64'd0;
        frame_out    <= frame1;
      end else if (!mode1) begin
        physical_out <= phys1;
        frame_out    <= frame1;
      end else begin
        physical_out <= 64'd0;
        frame_out    <= (new_frame & VisMask) | (frame1 & ~VisMask);
      end
    end
  end

endmodule

`default_nettype wire

[design/can_signal_pack_unpack.sv]
// ----------------------------------------------------------------------------
// can_signal_pack_unpack
// Packs or unpacks one scaled signal of a CAN payload, one item per cycle.
// ----------------------------------------------------------------------------
// Pipeline from input transfer to result: 5 front stages, 64 divider cells,
//   rounding stage, output register.
// Throughput: one item per cycle; the whole pipe holds while the output stalls.
// Latency is set by the 64-cell division chain, one quotient bit per cell.
// Reset clears all valid flags and loads the register defaults (unit scale).
`default_nettype none

module can_signal_pack_unpack
  import cspu_pkg::*;
#(
  parameter int FRAME_BITS = FrameBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode,
  input  wire logic [63:0]        frame_data,
  input  wire logic signed [63:0] physical_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [63:0]      physical_out,
  output logic [63:0]             frame_out,
  output logic                    ok
);

  logic [5:0]  sig_start;
  logic [6:0]  sig_len;
  logic        motorola_order;
  logic        signed_signal;
  logic [31:0] scale_factor;
  logic [63:0] offset_value;

  cspu_cfg_t   cfg;
  logic [31:0] scale_eff;
  logic        en;
  logic [63:0] phys_q;

  cspu_cell_t link [DivSteps+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_start      <= 6'd0;
      sig_len        <= 7'd0;
      motorola_order <= 1'b0;
      signed_signal  <= 1'b0;
      scale_factor   <= UnitScale;
      offset_value   <= 64'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_BIT: sig_start      <= cfg_data[5:0];
        CFG_LENGTH:    sig_len        <= cfg_data[6:0];
        CFG_MOTOROLA:  motorola_order <= cfg_data[0];
        CFG_SIGNED:    signed_signal  <= cfg_data[0];
        CFG_SCALE:     scale_factor   <= cfg_data[31:0];
        CFG_OFFSET:    offset_value   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    scale_eff      = (scale_factor == 32'd0) ? UnitScale : scale_factor;
    cfg.sig_start  = sig_start;
    cfg.sig_len    = sig_len;
    cfg.motorola   = motorola_order;
    cfg.signed_sig = signed_signal;
    cfg.sneg       = scale_eff[31];
    cfg.smag       = scale_eff[31] ? (32'd0 - scale_eff) : scale_eff;
    cfg.offset     = offset_value;
  end

  // hold every stage while a result waits on a stalled output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  cspu_front #(.FRAME_BITS(FRAME_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .in_take     (in_valid && en),
    .mode        (mode),
    .frame_data  (frame_data),
    .physical_in (physical_in),
    .c_out       (link[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_cell
    cspu_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .smag  (cfg.smag),
      .c_in  (link[k]),
      .c_out (link[k+1])
    );
  end

  cspu_back #(.FRAME_BITS(FRAME_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .c_in         (link[DivSteps]),
    .out_valid    (out_valid),
    .physical_out (phys_q),
    .frame_out    (frame_out),
    .ok           (ok)
  );

  assign physical_out = phys_q;

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_bad_length_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> physical_out == 64'sd0)
    else $error("invalid length gave a non-zero physical value");

  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(link[DivSteps].valid))
    else $error("divider chain advanced during stall");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for can_signal_pack_unpack. Each phase writes the six
// signal registers while the pipe is empty, then streams decode and encode
// transfers. A bit-exact predictor checks every result in order. Sender
// bursts, receiver stalls and one long output hold-off load the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import cspu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 150;
  localparam int RandomItems   = 1800;
  localparam int LongHoldAt    = 600;
  localparam int LongHoldLen   = 400;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_t;

  typedef struct {
    logic signed [63:0] phys;
    logic [63:0]        frame;
    logic               ok;
  } signal_result_t;

  class signal_scoreboard;
    logic [5:0]  sig_start;
    logic [6:0]  sig_len;
    logic        motorola;
    logic        signed_sig;
    logic [31:0] scale;
    logic [63:0] offset;
    signal_result_t pending[$];
    int mismatches;
    int checked;

    function new();
      sig_start  = '0;
      sig_len    = '0;
      motorola   = 1'b0;
      signed_sig = 1'b0;
      scale      = UnitScale;
      offset     = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [63:0] d);
      case (idx)
        CFG_START_BIT: sig_start  = d[5:0];
        CFG_LENGTH:    sig_len    = d[6:0];
        CFG_MOTOROLA:  motorola   = d[0];
        CFG_SIGNED:    signed_sig = d[0];
        CFG_SCALE:     scale      = d[31:0];
        CFG_OFFSET:    offset     = d;
        default: ;
      endcase
    endfunction

    function logic [31:0] scale_magnitude(output logic neg);
      logic [31:0] s;
      s = (scale == '0) ? UnitScale : scale;
      neg = s[31];
      return neg ? -s : s;
    endfunction

    function logic [63:0] extract_field(logic [63:0] frame);
      logic [63:0] raw;
      int n;
      raw = '0;
      n = sig_start;
      for (int i = 0; i < sig_len; i++) begin
        if (motorola) begin
          raw = {raw[62:0], (n < 64) ? frame[n] : 1'b0};
          n = (n % 8 == 0) ? n + 15 : n - 1;
        end else if (sig_start + i < 64) begin
          raw[i] = frame[sig_start + i];
        end
      end
      return raw;
    endfunction

    function logic [63:0] insert_field(logic [63:0] frame, logic [63:0] raw);
      int n;
      n = sig_start;
      for (int i = 0; i < sig_len; i++) begin
        if (motorola) begin
          if (n < 64) frame[n] = raw[sig_len - 1 - i];
          n = (n % 8 == 0) ? n + 15 : n - 1;
        end else if (sig_start + i < 64) begin
          frame[sig_start + i] = raw[i];
        end
      end
      return frame;
    endfunction

    function logic [63:0] scale_to_physical(logic [63:0] raw);
      logic [63:0]  vmag;
      logic         vneg, sneg;
      logic [31:0]  smag;
      logic [127:0] acc;
      vmag = raw;
      vneg = 1'b0;
      if (signed_sig && sig_len < 64 && raw[sig_len - 1]) begin
        vneg = 1'b1;
        vmag = -(raw | ({64{1'b1}} << sig_len));
      end else if (signed_sig && sig_len == 64 && raw[63]) begin
        vneg = 1'b1;
        vmag = -raw;
      end
      smag = scale_magnitude(sneg);
      acc = {64'd0, vmag} * {96'd0, smag};
      if (vneg != sneg) acc = -acc;
      acc = acc + {{64{offset[63]}}, offset};
      if (acc[127:64] == {64{acc[63]}}) return acc[63:0];
      return acc[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    function logic [63:0] physical_to_raw(logic [63:0] phys);
      logic        pneg, oneg, dneg, sneg, neg;
      logic [63:0] pmag, omag, dmag, q, r, maxp, maxn, val;
      logic [31:0] smag;
      pneg = phys[63];
      oneg = offset[63];
      pmag = pneg ? -phys : phys;
      omag = oneg ? -offset : offset;
      if (pneg != oneg) begin
        dneg = pneg;
        dmag = pmag + omag;
      end else if (pmag >= omag) begin
        dneg = pneg;
        dmag = pmag - omag;
      end else begin
        dneg = !pneg;
        dmag = omag - pmag;
      end
      smag = scale_magnitude(sneg);
      q = dmag / {32'd0, smag};
      r = dmag % {32'd0, smag};
      if (2 * r >= {32'd0, smag}) q = q + 1;
      neg = (dneg != sneg) && q != 0;
      if (signed_sig) begin
        maxn = 64'd1 << (sig_len - 1);
        maxp = maxn - 1;
      end else begin
        maxn = '0;
        maxp = (sig_len >= 64) ? {1'b0, {63{1'b1}}} : (64'd1 << sig_len) - 1;
      end
      if (neg) begin
        if (q > maxn) q = maxn;
        val = -q;
      end else begin
        if (q > maxp) q = maxp;
        val = q;
      end
      if (sig_len < 64) val = val & ((64'd1 << sig_len) - 1);
      return val;
    endfunction

    function void note_input(logic m, logic [63:0] frame, logic [63:0] phys);
      signal_result_t e;
      e.phys  = '0;
      e.frame = frame;
      e.ok    = 1'b0;
      if (sig_len != 0 && sig_len <= 64) begin
        e.ok = 1'b1;
        if (m == OP_DECODE) e.phys = scale_to_physical(extract_field(frame));
        else e.frame = insert_field(frame, physical_to_raw(phys));
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [63:0] phys, logic [63:0] frame, logic okv);
      signal_result_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (phys !== e.phys || frame !== e.frame || okv !== e.ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp phys=%h frame=%h ok=%b got phys=%h frame=%h ok=%b",
                   checked, e.phys, e.frame, e.ok, phys, frame, okv);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid, in_stall, mode;
  logic [63:0] frame_data;
  logic signed [63:0] physical_in;
  logic out_valid, out_stall, ok;
  logic signed [63:0] physical_out;
  logic [63:0] frame_out;

  signal_scoreboard sb;
  int idle_cycles;
  int items_sent;
  int burst_left;
  int phases;
  int decodes, encodes;

  can_signal_pack_unpack u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .frame_data(frame_data),
    .physical_in(physical_in),
    .out_valid(out_valid), .out_stall(out_stall), .physical_out(physical_out),
    .frame_out(frame_out), .ok(ok)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // monitors and watchdog
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_idx_t'(cfg_index), cfg_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_input(mode, frame_data, physical_in);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(physical_out, frame_out, ok);
        moved = 1'b1;
      end
      if (moved) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transfer for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off while the sender keeps going
  initial begin
    int seg_left, pct;
    bit long_done;
    out_stall = 1'b0;
    seg_left = 0;
    pct = 0;
    long_done = 0;
    forever begin
      @(negedge clk);
      if (!long_done && items_sent >= LongHoldAt) begin
        long_done = 1;
        out_stall <= 1'b1;
        repeat (LongHoldLen) @(negedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(200, 20);
        case ($urandom_range(3, 0))
          0: pct = 0;
          1: pct = 10;
          2: pct = 50;
          default: pct = 90;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(99, 0) < pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // valid stays high between back-to-back writes; configure drops it at the end
  task automatic write_reg(cfg_idx_t idx, logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // stop sending and hold until the pipe is empty before touching the registers
  task automatic configure(int first_bit, int len, bit moto, bit sgn,
                           logic [31:0] scl, logic [63:0] off);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    write_reg(CFG_START_BIT, first_bit);
    write_reg(CFG_LENGTH, len);
    write_reg(CFG_MOTOROLA, moto);
    write_reg(CFG_SIGNED, sgn);
    write_reg(CFG_SCALE, {{32{scl[31]}}, scl});
    write_reg(CFG_OFFSET, off);
    cfg_valid <= 1'b0;
    phases++;
  endtask

  task automatic send_item(op_t op, logic [63:0] frame, logic [63:0] phys);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    in_valid    <= 1'b1;
    mode        <= op;
    frame_data  <= frame;
    physical_in <= phys;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (op == OP_DECODE) decodes++;
    else encodes++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pick_phys(logic [63:0] off);
    logic [63:0] v;
    case ($urandom_range(5, 0))
      0: v = {1'b0, {63{1'b1}}};
      1: v = {1'b1, 63'd0};
      default: v = off + ($signed(rand64()) >>> $urandom_range(63, 0));
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] scl;
    logic [63:0] off;
    int len, n, cnt;
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_START_BIT;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = OP_DECODE;
    frame_data = '0;
    physical_in = '0;
    idle_cycles = 0;
    items_sent = 0;
    burst_left = 0;
    phases = 0;
    decodes = 0;
    encodes = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: zero length
    send_item(OP_DECODE, {64{1'b1}}, '0);
    send_item(OP_ENCODE, 64'h0123_4567_89ab_cdef, 64'h10000);
    // full-width unsigned Intel
    configure(0, 64, 0, 0, UnitScale, '0);
    send_item(OP_DECODE, {64{1'b1}}, '0);
    send_item(OP_DECODE, '0, '0);
    send_item(OP_ENCODE, '0, {1'b0, {63{1'b1}}});
    send_item(OP_ENCODE, {64{1'b1}}, {1'b1, 63'd0});
    // full-width signed Motorola, zero scale acts as unity
    configure(7, 64, 1, 1, 32'd0, {1'b0, {63{1'b1}}});
    send_item(OP_DECODE, {64{1'b1}}, '0);
    send_item(OP_DECODE, 64'h0000_0000_0000_0080, '0);
    send_item(OP_ENCODE, '0, {1'b1, 63'd0});
    send_item(OP_ENCODE, '0, {1'b0, {63{1'b1}}});
    // field running off the top of the frame, most negative scale
    configure(60, 12, 0, 1, 32'h8000_0000, {1'b1, 63'd0});
    send_item(OP_DECODE, {64{1'b1}}, '0);
    send_item(OP_ENCODE, '0, {1'b0, {63{1'b1}}});
    send_item(OP_ENCODE, {64{1'b1}}, 64'h1234);
    // Motorola field crossing bytes, negative unit scale
    configure(3, 20, 1, 0, 32'hffff_0000, 64'h8000);
    send_item(OP_DECODE, 64'h5a5a_a5a5_f00f_0ff0, '0);
    send_item(OP_ENCODE, '0, -64'sh18000);
    send_item(OP_ENCODE, {64{1'b1}}, 64'sh28000);
    // Motorola walk leaving the frame from the top byte
    configure(58, 30, 1, 1, 32'h7fff_ffff, '0);
    send_item(OP_DECODE, {64{1'b1}}, '0);
    send_item(OP_ENCODE, '0, -64'sd5);
    // one-bit signal at the last bit
    configure(63, 1, 0, 1, UnitScale, '0);
    send_item(OP_DECODE, {1'b1, 63'd0}, '0);
    send_item(OP_ENCODE, '0, -64'sh10000);
    // out-of-range lengths
    configure(5, 65, 0, 0, UnitScale, '0);
    send_item(OP_DECODE, 64'hdead_beef_0000_1111, '0);
    configure(5, 127, 1, 1, UnitScale, '0);
    send_item(OP_ENCODE, 64'hdead_beef_0000_1111, 64'h7777);

    n = 0;
    while (n < RandomItems) begin
      case ($urandom_range(9, 0))
        0: len = 0;
        1: len = $urandom_range(127, 65);
        2: len = 64;
        default: len = $urandom_range(64, 1);
      endcase
      case ($urandom_range(6, 0))
        0: scl = '0;
        1: scl = UnitScale;
        2: scl = 32'h8000_0000;
        3: scl = 32'h7fff_ffff;
        4: scl = $urandom;
        default: scl = ($urandom_range(1, 0) ? -1 : 1) * $urandom_range(1 << 20, 1);
      endcase
      case ($urandom_range(4, 0))
        0: off = '0;
        1: off = {1'b1, 63'd0};
        2: off = {1'b0, {63{1'b1}}};
        default: off = $signed(rand64()) >>> $urandom_range(63, 0);
      endcase
      configure($urandom_range(63, 0), len, $urandom_range(1, 0), $urandom_range(1, 0),
                scl, off);
      cnt = $urandom_range(100, 20);
      // stretch the phase that meets the long hold-off so the pipe fills up
      if (items_sent < LongHoldAt && items_sent + 100 >= LongHoldAt)
        cnt = LongHoldAt - items_sent + 150;
      repeat (cnt) begin
        if ($urandom_range(1, 0)) send_item(OP_DECODE, rand64(), rand64());
        else send_item(OP_ENCODE, rand64(), pick_phys(off));
        n++;
      end
    end
    idle_input();

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    $display("Covered %0d phases, %0d decode and %0d encode transfers, %0d results checked",
             phases, decodes, encodes, sb.checked);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
